// ===== hdl/fsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsfe_pkg
// Types and constants shared by the shape function evaluator.
// ----------------------------------------------------------------------------
package fsfe_pkg;

    localparam int NODE_W = 3;
    localparam int VAL_W  = 16;

    typedef enum logic [1:0] {
        KIND_LINEAR      = 2'd0,
        KIND_QUADRATIC   = 2'd1,
        KIND_BILINEAR    = 2'd2,
        KIND_SERENDIPITY = 2'd3
    } kind_t;

    // Rounding right shift applied to a product before it leaves the block.
    typedef enum logic [2:0] {
        RND_0  = 3'd0,
        RND_1  = 3'd1,
        RND_2  = 3'd2,
        RND_F  = 3'd3,
        RND_F1 = 3'd4,
        RND_F2 = 3'd5
    } rnd_t;

    typedef struct packed {
        kind_t             kind;
        logic [NODE_W-1:0] node;
        logic              last;
    } node_ctl_t;

    function automatic logic [NODE_W-1:0] last_node_of(input kind_t kind);
        logic [NODE_W-1:0] n;
        case (kind)
            KIND_LINEAR:      n = NODE_W'(1);
            KIND_QUADRATIC:   n = NODE_W'(2);
            KIND_BILINEAR:    n = NODE_W'(3);
            KIND_SERENDIPITY: n = NODE_W'(7);
            default:          n = NODE_W'(1);
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/fem_shape_function_eval_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fem_shape_function_eval_core
// Lagrange and serendipity shape functions with their gradients, one result
// transaction per element node.
// ----------------------------------------------------------------------------
// A point (xi, eta) is taken on the slave stream and held while a node counter
// issues one node per cycle, unless the pipeline stalls, into a five-stage
// pipeline, so a point covers 2, 3, 4 or 8 nodes (linear, quadratic, bilinear,
// serendipity element) and the next point is taken in the cycle its last node
// issues. Each node passes through stages 1 to 5 and leaves as one master
// transaction, with tlast on the final node. Back-pressure stalls the pipeline
// without losing or repeating a node. The element kind is sampled when a point
// is taken; write it only while the block is idle.
module fem_shape_function_eval_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // element_kind
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // xi[15:0], eta[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // node_index[2:0], shape_value[18:3],
                                        // grad_xi[34:19], grad_eta[50:35], zero pad
    output logic        m_axis_tlast    // last_node
);
    import fsfe_pkg::*;

    localparam int OW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 3;
    localparam int PW = 2 * OW;

    localparam logic signed [OW-1:0] ONE  = OW'(1) << FRAC_BITS;
    localparam logic signed [OW-1:0] HALF = ONE >>> 1;
    localparam logic signed [OW-1:0] UNIT = OW'(1);

    localparam logic signed [PW:0] RC_1  = (PW+1)'(1);
    localparam logic signed [PW:0] RC_2  = (PW+1)'(2);
    localparam logic signed [PW:0] RC_F  = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW:0] RC_F1 = (PW+1)'(1) << FRAC_BITS;
    localparam logic signed [PW:0] RC_F2 = (PW+1)'(1) << (FRAC_BITS + 1);
    localparam logic signed [PW:0] SAT_HI = (PW+1)'(32767);
    localparam logic signed [PW:0] SAT_LO = -(PW+1)'(32768);
    localparam logic signed [32:0] SQ_RC = 33'(1) << (FRAC_BITS - 1);

    function automatic logic signed [15:0] clamp16(input logic signed [15:0] raw);
        logic signed [OW-1:0] v;
        v = OW'(raw);
        if (v > ONE)
        begin
            v = ONE;
        end
        else if (v < -ONE)
        begin
            v = -ONE;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [PW-1:0] p,
                                                          input rnd_t r);
        logic signed [PW:0] w;
        logic signed [PW:0] s;
        w = (PW+1)'(p);
        case (r)
            RND_0:   s = w;
            RND_1:   s = (w + RC_1) >>> 1;
            RND_2:   s = (w + RC_2) >>> 2;
            RND_F:   s = (w + RC_F) >>> FRAC_BITS;
            RND_F1:  s = (w + RC_F1) >>> (FRAC_BITS + 1);
            RND_F2:  s = (w + RC_F2) >>> (FRAC_BITS + 2);
            default: s = w;
        endcase
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        return s[VAL_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    kind_t kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_LINEAR;
        end
        else if (cfg_we)
        begin
            kind_reg <= kind_t'(cfg_wdata);
        end
    end

    // ------------------------------------------------------------------------
    // Stage enables: a stage moves when it is empty or the next one moves.
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    // ------------------------------------------------------------------------
    // Point holding register and node counter
    // ------------------------------------------------------------------------
    logic                    hold_valid_reg;
    logic signed [15:0]      hold_x_reg, hold_y_reg;
    kind_t                   hold_kind_reg;
    logic [NODE_W-1:0]       cnt_reg;
    logic                    issue, issue_last, s_acc;

    assign issue_last    = (cnt_reg == last_node_of(hold_kind_reg));
    assign issue         = hold_valid_reg && en1;
    assign s_axis_tready = !hold_valid_reg || (en1 && issue_last);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (s_acc)
        begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= '0;
        end
        else if (issue && issue_last)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + NODE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            hold_x_reg    <= clamp16(s_axis_tdata[15:0]);
            hold_y_reg    <= clamp16(s_axis_tdata[31:16]);
            hold_kind_reg <= kind_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: linear terms and the corner factor selection
    // ------------------------------------------------------------------------
    node_ctl_t            ctl1_next, ctl1_reg;
    logic signed [OW-1:0] xw0, yw0;
    logic signed [OW-1:0] xm1_next, xp1_next, ym1_next, yp1_next, p1_next, q1_next;
    logic                 sgx1_next, sgy1_next;
    logic signed [15:0]   x1_reg, y1_reg;
    logic signed [OW-1:0] xm1_reg, xp1_reg, ym1_reg, yp1_reg, p1_reg, q1_reg;
    logic                 sgx1_reg, sgy1_reg;

    always_comb
    begin
        xw0 = OW'(hold_x_reg);
        yw0 = OW'(hold_y_reg);
        xm1_next = ONE - xw0;
        xp1_next = ONE + xw0;
        ym1_next = ONE - yw0;
        yp1_next = ONE + yw0;
        // Corner order (-1,-1), (1,-1), (1,1), (-1,1) along the low counter bits.
        sgx1_next = cnt_reg[0] ^ cnt_reg[1];
        sgy1_next = cnt_reg[1];
        p1_next = sgx1_next ? xp1_next : xm1_next;
        q1_next = sgy1_next ? yp1_next : ym1_next;
        ctl1_next.kind = hold_kind_reg;
        ctl1_next.node = cnt_reg;
        ctl1_next.last = issue_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= hold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ctl1_reg <= ctl1_next;
            x1_reg   <= hold_x_reg;
            y1_reg   <= hold_y_reg;
            xm1_reg  <= xm1_next;
            xp1_reg  <= xp1_next;
            ym1_reg  <= ym1_next;
            yp1_reg  <= yp1_next;
            p1_reg   <= p1_next;
            q1_reg   <= q1_next;
            sgx1_reg <= sgx1_next;
            sgy1_reg <= sgy1_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: squares and the bilinear corner product
    // ------------------------------------------------------------------------
    logic signed [31:0]   sx2_next, sy2_next, sx2_reg, sy2_reg;
    logic signed [PW-1:0] pq2_next, pq2_reg;
    node_ctl_t            ctl2_reg;
    logic signed [15:0]   x2_reg, y2_reg;
    logic signed [OW-1:0] xm2_reg, xp2_reg, ym2_reg, yp2_reg, p2_reg, q2_reg;
    logic                 sgx2_reg, sgy2_reg;

    assign sx2_next = x1_reg * x1_reg;
    assign sy2_next = y1_reg * y1_reg;
    assign pq2_next = p1_reg * q1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sx2_reg  <= sx2_next;
            sy2_reg  <= sy2_next;
            pq2_reg  <= pq2_next;
            ctl2_reg <= ctl1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            xm2_reg  <= xm1_reg;
            xp2_reg  <= xp1_reg;
            ym2_reg  <= ym1_reg;
            yp2_reg  <= yp1_reg;
            p2_reg   <= p1_reg;
            q2_reg   <= q1_reg;
            sgx2_reg <= sgx1_reg;
            sgy2_reg <= sgy1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: round the squares and the corner product
    // ------------------------------------------------------------------------
    logic signed [32:0]   sxr, syr;
    logic signed [PW:0]   cr;
    logic signed [OW-1:0] x2c_next, e2c_next, c3_next;
    logic signed [OW-1:0] x2c_reg, e2c_reg, c3_reg;
    node_ctl_t            ctl3_reg;
    logic signed [15:0]   x3_reg, y3_reg;
    logic signed [OW-1:0] xm3_reg, xp3_reg, ym3_reg, yp3_reg, p3_reg, q3_reg;
    logic                 sgx3_reg, sgy3_reg;

    always_comb
    begin
        sxr = (33'(sx2_reg) + SQ_RC) >>> FRAC_BITS;
        syr = (33'(sy2_reg) + SQ_RC) >>> FRAC_BITS;
        cr  = ((PW+1)'(pq2_reg) + RC_F) >>> FRAC_BITS;
        x2c_next = ONE - OW'(sxr);
        e2c_next = ONE - OW'(syr);
        c3_next  = OW'(cr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            x2c_reg  <= x2c_next;
            e2c_reg  <= e2c_next;
            c3_reg   <= c3_next;
            ctl3_reg <= ctl2_reg;
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            xm3_reg  <= xm2_reg;
            xp3_reg  <= xp2_reg;
            ym3_reg  <= ym2_reg;
            yp3_reg  <= yp2_reg;
            p3_reg   <= p2_reg;
            q3_reg   <= q2_reg;
            sgx3_reg <= sgx2_reg;
            sgy3_reg <= sgy2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: pick the factor pair of each output and multiply
    // ------------------------------------------------------------------------
    logic signed [OW-1:0] x3w, y3w, sx3, sy3;
    logic signed [OW-1:0] va, vb, ga, gb, ha, hb;
    rnd_t                 vr_next, gr_next, hr_next;
    rnd_t                 vr4_reg, gr4_reg, hr4_reg;
    logic signed [PW-1:0] vp4_next, gp4_next, hp4_next;
    logic signed [PW-1:0] vp4_reg, gp4_reg, hp4_reg;
    node_ctl_t            ctl4_reg;

    always_comb
    begin
        x3w = OW'(x3_reg);
        y3w = OW'(y3_reg);
        // Signed coordinates of the current corner applied to x and y.
        sx3 = sgx3_reg ? x3w : -x3w;
        sy3 = sgy3_reg ? y3w : -y3w;
        va = '0;
        vb = '0;
        ga = '0;
        gb = '0;
        ha = '0;
        hb = '0;
        vr_next = RND_0;
        gr_next = RND_0;
        hr_next = RND_0;
        case (ctl3_reg.kind)
            KIND_LINEAR:
            begin
                vb = UNIT;
                gb = UNIT;
                vr_next = RND_1;
                if (ctl3_reg.node[0])
                begin
                    va = xp3_reg;
                    ga = HALF;
                end
                else
                begin
                    va = xm3_reg;
                    ga = -HALF;
                end
            end
            KIND_QUADRATIC:
            begin
                gb = UNIT;
                case (ctl3_reg.node[1:0])
                    2'd0:
                    begin
                        va = -x3w;
                        vb = xm3_reg;
                        vr_next = RND_F1;
                        ga = x3w - HALF;
                    end
                    2'd1:
                    begin
                        va = x3w;
                        vb = xp3_reg;
                        vr_next = RND_F1;
                        ga = x3w + HALF;
                    end
                    default:
                    begin
                        va = xm3_reg;
                        vb = xp3_reg;
                        vr_next = RND_F;
                        ga = -(x3w <<< 1);
                    end
                endcase
            end
            KIND_BILINEAR:
            begin
                va = p3_reg;
                vb = q3_reg;
                vr_next = RND_F2;
                ga = sgx3_reg ? q3_reg : -q3_reg;
                gb = UNIT;
                gr_next = RND_2;
                ha = sgy3_reg ? p3_reg : -p3_reg;
                hb = UNIT;
                hr_next = RND_2;
            end
            KIND_SERENDIPITY:
            begin
                if (!ctl3_reg.node[2])
                begin
                    vr_next = RND_F1;
                    case (ctl3_reg.node[1:0])
                        2'd0:
                        begin
                            va = xm3_reg;
                            vb = e2c_reg;
                            ga = -e2c_reg;
                            gb = UNIT;
                            gr_next = RND_1;
                            ha = -y3w;
                            hb = xm3_reg;
                            hr_next = RND_F;
                        end
                        2'd1:
                        begin
                            va = x2c_reg;
                            vb = ym3_reg;
                            ga = -x3w;
                            gb = ym3_reg;
                            gr_next = RND_F;
                            ha = -x2c_reg;
                            hb = UNIT;
                            hr_next = RND_1;
                        end
                        2'd2:
                        begin
                            va = xp3_reg;
                            vb = e2c_reg;
                            ga = e2c_reg;
                            gb = UNIT;
                            gr_next = RND_1;
                            ha = -y3w;
                            hb = xp3_reg;
                            hr_next = RND_F;
                        end
                        default:
                        begin
                            va = x2c_reg;
                            vb = yp3_reg;
                            ga = -x3w;
                            gb = yp3_reg;
                            gr_next = RND_F;
                            ha = x2c_reg;
                            hb = UNIT;
                            hr_next = RND_1;
                        end
                    endcase
                end
                else
                begin
                    // Corner: N = c*(+-x +-y - 1)/4, gradients in factored form.
                    va = c3_reg;
                    vb = sx3 + sy3 - ONE;
                    vr_next = RND_F2;
                    ga = q3_reg;
                    gb = (x3w <<< 1) + ((sgx3_reg == sgy3_reg) ? y3w : -y3w);
                    gr_next = RND_F2;
                    ha = p3_reg;
                    hb = (y3w <<< 1) + ((sgx3_reg == sgy3_reg) ? x3w : -x3w);
                    hr_next = RND_F2;
                end
            end
            default:
            begin
                va = '0;
            end
        endcase
        vp4_next = va * vb;
        gp4_next = ga * gb;
        hp4_next = ha * hb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            vp4_reg  <= vp4_next;
            gp4_reg  <= gp4_next;
            hp4_reg  <= hp4_next;
            vr4_reg  <= vr_next;
            gr4_reg  <= gr_next;
            hr4_reg  <= hr_next;
            ctl4_reg <= ctl3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: rounding shift, saturation, output register
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] val5_next, gx5_next, gy5_next;
    logic signed [VAL_W-1:0] val5_reg, gx5_reg, gy5_reg;
    node_ctl_t               ctl5_reg;

    always_comb
    begin
        val5_next = round_sat(vp4_reg, vr4_reg);
        gx5_next  = round_sat(gp4_reg, gr4_reg);
        gy5_next  = round_sat(hp4_reg, hr4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en5)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            val5_reg <= val5_next;
            gx5_reg  <= gx5_next;
            gy5_reg  <= gy5_next;
            ctl5_reg <= ctl4_reg;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tlast  = ctl5_reg.last;
    assign m_axis_tdata  = {5'b0, gy5_reg, gx5_reg, val5_reg, ctl5_reg.node};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (ctl5_reg.node == last_node_of(ctl5_reg.kind)))
        else $error("tlast on a node that is not the last of its element");

    a_one_dim_no_eta: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (ctl5_reg.kind == KIND_LINEAR || ctl5_reg.kind == KIND_QUADRATIC))
        |-> (gy5_reg == '0))
        else $error("nonzero eta gradient on a one-dimensional element");

    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !issue) |=> (hold_valid_reg && $stable(cnt_reg)))
        else $error("node counter moved while the pipeline was stalled");

    a_stage4_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !en4) |=> v4_reg)
        else $error("stalled node dropped from stage 4");

endmodule
